/* src/rbdo_pkg.sv */
// rbdo_pkg: shared types and constants for the drop-oldest ring buffer.
// Used by rbdo_cell and ring_buffer_drop_oldest; depends on nothing.
package rbdo_pkg;

  // Index fields in the chain structs cover the largest supported depth (256).
  localparam int IDX_W      = 8;
  localparam int ID_W       = 16;
  localparam int TIME_W     = 32;
  localparam int SLOT_OUT_W = 4;
  localparam int FREE_OUT_W = 5;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [TIME_W-1:0] tstamp_t;

  // Partial result carried cell to cell by the scan wave.
  typedef struct packed {
    logic    valid;
    logic    hi_found;    // first free slot at or after the tail
    idx_t    hi_idx;
    logic    lo_found;    // first free slot anywhere
    idx_t    lo_idx;
    logic    best_valid;  // running oldest slot
    tstamp_t best_time;
    idx_t    best_idx;
    logic    rd_used;     // contents of the head slot
    id_t     rd_id;
    tstamp_t rd_time;
  } scan_t;

  // Write or clear broadcast to every cell at the end of a transaction.
  typedef struct packed {
    logic    wr;
    logic    clr;
    idx_t    idx;
    id_t     id;
    tstamp_t tstamp;
  } cmd_t;

endpackage

/* src/rbdo_cell.sv */
// rbdo_cell: one slot of the ring buffer plus its stage of the scan chain.
// Depends on rbdo_pkg.
module rbdo_cell import rbdo_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  scan_t scan_in,
  output scan_t scan_out,
  input  idx_t  tail,
  input  idx_t  head,
  input  cmd_t  cmd
);

  localparam idx_t MY_IDX = IDX_W'(CELL_IDX);

  id_t     slot_id;
  tstamp_t slot_time;
  logic    slot_used;
  scan_t   scan_next;
  logic    hit;

  assign hit = (cmd.idx == MY_IDX);

  always_comb begin
    scan_next = scan_in;
    if (!slot_used) begin
      if (!scan_in.hi_found && (MY_IDX >= tail)) begin
        scan_next.hi_found = 1'b1;
        scan_next.hi_idx   = MY_IDX;
      end
      if (!scan_in.lo_found) begin
        scan_next.lo_found = 1'b1;
        scan_next.lo_idx   = MY_IDX;
      end
    end
    // strict compare: lower index keeps ties
    if (!scan_in.best_valid || (slot_time < scan_in.best_time)) begin
      scan_next.best_valid = 1'b1;
      scan_next.best_time  = slot_time;
      scan_next.best_idx   = MY_IDX;
    end
    if (MY_IDX == head) begin
      scan_next.rd_used = slot_used;
      scan_next.rd_id   = slot_id;
      scan_next.rd_time = slot_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= 1'b0;
    end else if (hit && cmd.wr) begin
      slot_used <= 1'b1;
    end else if (hit && cmd.clr) begin
      slot_used <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit && cmd.wr) begin
      slot_id   <= cmd.id;
      slot_time <= cmd.tstamp;
    end
  end

endmodule

/* src/ring_buffer_drop_oldest.sv */
// ring_buffer_drop_oldest: slotted ring buffer of timestamped requests that
// overwrites the oldest entry when full. Depends on rbdo_pkg and rbdo_cell.
//
// Channel     | Handshake          | Fields
// ------------+--------------------+-----------------------------------------
// command in  | start, busy        | operation, request_id, start_time
// result out  | done (1-cycle)     | slot_index, stored_without_drop,
//             |                    | removed_valid, removed_id, removed_time,
//             |                    | free_slots, is_empty, is_full
//
// A transaction is taken when start is high and busy is low. A scan wave then
// walks the row of BUFFER_DEPTH cells, one cell per cycle. busy drops together
// with done, so a new command is taken only after the previous result is out;
// the length of the cell chain sets how long a transaction takes.
// Synchronous reset empties every slot, zeroes the pointers and sets the free
// count to BUFFER_DEPTH; no clearing pass follows. done is asserted for
// exactly one cycle and cannot be stalled.
module ring_buffer_drop_oldest import rbdo_pkg::*; #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  operation,
  input  logic [ID_W-1:0]       request_id,
  input  logic [TIME_W-1:0]     start_time,
  output logic                  done,
  output logic [SLOT_OUT_W-1:0] slot_index,
  output logic                  stored_without_drop,
  output logic                  removed_valid,
  output logic [ID_W-1:0]       removed_id,
  output logic [TIME_W-1:0]     removed_time,
  output logic [FREE_OUT_W-1:0] free_slots,
  output logic                  is_empty,
  output logic                  is_full
);

  localparam int PW = $clog2(BUFFER_DEPTH);       // slot pointer width
  localparam int CW = $clog2(BUFFER_DEPTH + 1);   // free count width

  typedef enum logic {IDLE, SCAN} state_t;

  state_t          state;
  logic            op_r;
  id_t             id_r;
  tstamp_t         time_r;
  logic [PW-1:0]   head;
  logic [PW-1:0]   tail;
  logic [CW-1:0]   free_count;
  logic            launch;

  scan_t           chain [BUFFER_DEPTH+1];
  scan_t           last;
  cmd_t            cmd;
  logic            fin;

  logic [PW-1:0]   slot_sel;
  logic [PW-1:0]   head_next;
  logic [PW-1:0]   tail_next;
  logic [CW-1:0]   free_next;
  logic            no_drop;
  logic            rvalid;
  id_t             rid;
  tstamp_t         rtime;
  logic            do_wr;
  logic            do_clr;
  logic [31:0]     slot_wide;
  logic [31:0]     free_wide;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    nxt = (p == PW'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign busy = (state == SCAN);

  // Wave enters the first cell with nothing found yet.
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = launch;
  end

  genvar g;
  generate
    for (g = 0; g < BUFFER_DEPTH; g++) begin : g_cell
      rbdo_cell #(.CELL_IDX(g)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .scan_in  (chain[g]),
        .scan_out (chain[g+1]),
        .tail     (IDX_W'(tail)),
        .head     (IDX_W'(head)),
        .cmd      (cmd)
      );
    end
  endgenerate

  assign last = chain[BUFFER_DEPTH];
  assign fin  = busy && last.valid;

  // Decide the transaction once the wave leaves the last cell.
  always_comb begin
    slot_sel  = head;
    head_next = head;
    tail_next = tail;
    free_next = free_count;
    no_drop   = 1'b0;
    rvalid    = 1'b0;
    rid       = '0;
    rtime     = '0;
    do_wr     = 1'b0;
    do_clr    = 1'b0;
    if (op_r == OP_ADD) begin
      do_wr = 1'b1;
      if (free_count != '0) begin
        // circular first-free from tail; fall back to tail if none seen
        if (last.hi_found) begin
          slot_sel = last.hi_idx[PW-1:0];
        end else if (last.lo_found) begin
          slot_sel = last.lo_idx[PW-1:0];
        end else begin
          slot_sel = tail;
        end
        tail_next = nxt(slot_sel);
        free_next = free_count - 1'b1;
        no_drop   = 1'b1;
      end else begin
        // full: overwrite the oldest
        slot_sel  = last.best_idx[PW-1:0];
        tail_next = slot_sel;
        if (head == slot_sel) begin
          head_next = nxt(head);
        end
      end
    end else begin
      if (free_count != CW'(BUFFER_DEPTH)) begin
        do_clr    = 1'b1;
        rvalid    = last.rd_used;
        head_next = nxt(head);
        free_next = free_count + 1'b1;
        if (last.rd_used) begin
          rid   = last.rd_id;
          rtime = last.rd_time;
        end
      end
    end
  end

  always_comb begin
    cmd.wr     = fin && do_wr;
    cmd.clr    = fin && do_clr;
    cmd.idx    = IDX_W'(slot_sel);
    cmd.id     = id_r;
    cmd.tstamp = time_r;
  end

  assign slot_wide = 32'(slot_sel);
  assign free_wide = 32'(free_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      launch     <= 1'b0;
      done       <= 1'b0;
      head       <= '0;
      tail       <= '0;
      free_count <= CW'(BUFFER_DEPTH);
    end else begin
      launch <= 1'b0;
      done   <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            op_r   <= operation;
            id_r   <= request_id;
            time_r <= start_time;
            launch <= 1'b1;
            state  <= SCAN;
          end
        end
        SCAN: begin
          if (last.valid) begin
            head                <= head_next;
            tail                <= tail_next;
            free_count          <= free_next;
            slot_index          <= slot_wide[SLOT_OUT_W-1:0];
            stored_without_drop <= no_drop;
            removed_valid       <= rvalid;
            removed_id          <= rid;
            removed_time        <= rtime;
            free_slots          <= free_wide[FREE_OUT_W-1:0];
            is_empty            <= (free_next == CW'(BUFFER_DEPTH));
            is_full             <= (free_next == '0);
            done                <= 1'b1;
            state               <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start a scan");

  a_done_after_wave: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(fin))
    else $error("result strobe without a finished scan");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= CW'(BUFFER_DEPTH))
    else $error("free count above depth");

  a_full_empty_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(is_full && is_empty))
    else $error("buffer reported both full and empty");
`endif

endmodule
